// ===== design/dicc_pkg.sv =====
// Shared types and constants for the divide cycle count pipeline.
// Used by dicc_front, dicc_step_stage and div_instruction_cycle_count_core.
package dicc_pkg;

    // Half counts: the reported figure is always twice the working count.
    localparam int CntW             = 7;
    localparam int UnsBaseHalf      = 38;
    localparam int UnsOvfHalf       = 5;
    localparam int SgnBaseHalf      = 61;
    localparam int SgnOvfHalf       = 8;
    localparam int DivSteps         = 15;
    localparam int StepsPerStage    = 3;
    localparam int NumStepStages    = DivSteps / StepsPerStage;

    typedef struct packed {
        logic        req_type;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } req_t;

    typedef struct packed {
        logic [7:0] cycle_count;
        logic       zero_divisor;
    } rsp_t;

    // Item as it travels down the step stages.
    typedef struct packed {
        logic            sign_mode;
        logic            done;       // count already final (zero or overflow)
        logic            zero;
        logic [31:0]     w;          // partial remainder in upper half
        logic [15:0]     d;          // absolute divisor
        logic [CntW-1:0] cnt;
    } work_t;

endpackage

// ===== design/dicc_front.sv =====
// Entry stage: absolute values, overflow check and starting count.
// Depends on dicc_pkg.
module dicc_front import dicc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_ready,
    input  req_t  up_data,
    output logic  dn_valid,
    input  logic  dn_ready,
    output work_t dn_data
);

    logic            valid_reg;
    work_t           data_reg;
    work_t           data_next;
    logic            dvd_neg;
    logic            dvs_neg;
    logic [31:0]     a_dvd;
    logic [15:0]     a_dvs;
    logic            zero;
    logic            ovf;
    logic [CntW-1:0] cnt;

    always_comb
    begin
        dvd_neg = up_data.req_type & up_data.dividend[31];
        dvs_neg = up_data.req_type & up_data.divisor[15];
        a_dvd   = dvd_neg ? (32'd0 - up_data.dividend) : up_data.dividend;
        a_dvs   = dvs_neg ? (16'd0 - up_data.divisor) : up_data.divisor;
        zero    = (up_data.divisor == 16'd0);
        ovf     = (a_dvd[31:16] >= a_dvs);

        if (zero)
            cnt = '0;
        else if (!up_data.req_type)
            cnt = ovf ? CntW'(UnsOvfHalf) : CntW'(UnsBaseHalf);
        else if (ovf)
            cnt = CntW'(SgnOvfHalf) + CntW'(dvd_neg);
        else if (dvs_neg)
            cnt = CntW'(SgnBaseHalf) + CntW'(dvd_neg);
        else
            cnt = dvd_neg ? CntW'(SgnBaseHalf + 2) : CntW'(SgnBaseHalf - 1);

        data_next.sign_mode = up_data.req_type;
        data_next.done      = zero | ovf;
        data_next.zero      = zero;
        data_next.w         = a_dvd;
        data_next.d         = a_dvs;
        data_next.cnt       = cnt;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== design/dicc_step_stage.sv =====
// One pipeline stage running a few restoring divide steps with cycle counting.
// Depends on dicc_pkg.
module dicc_step_stage import dicc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_ready,
    input  work_t up_data,
    output logic  dn_valid,
    input  logic  dn_ready,
    output work_t dn_data
);

    logic  valid_reg;
    work_t data_reg;
    work_t data_next;

    always_comb
    begin
        logic        c;
        logic [16:0] top;
        logic        q;
        data_next = up_data;
        for (int k = 0; k < StepsPerStage; k++)
        begin
            // shifted-out bit makes the compare always pass
            c   = data_next.w[31];
            top = {c, data_next.w[30:15]};
            q   = (top >= {1'b0, data_next.d});
            data_next.w[31:16] = q ? 16'(top - {1'b0, data_next.d}) : top[15:0];
            data_next.w[15:0]  = {data_next.w[14:0], 1'b0};
            if (!up_data.done)
            begin
                if (up_data.sign_mode)
                    data_next.cnt = data_next.cnt + CntW'(!q);
                else if (!c)
                    data_next.cnt = data_next.cnt + (q ? CntW'(1) : CntW'(2));
            end
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.done |-> data_reg.w[31:16] < data_reg.d)
        else $error("partial remainder not below divisor");

    a_done_count_small: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.done |-> data_reg.cnt <= CntW'(SgnOvfHalf + 1))
        else $error("early result count out of range");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dn_ready |=> valid_reg && $stable(data_reg))
        else $error("stage changed while blocked");
`endif

endmodule

// ===== design/div_instruction_cycle_count_core.sv =====
// Top level of the divide instruction cycle count pipeline.
// Depends on dicc_pkg, dicc_front and dicc_step_stage.
//
// Request channel: req_valid/req_stall/req_data carry a mode bit (signed or
// unsigned), a 32-bit dividend and a 16-bit divisor. Response channel:
// rsp_valid/rsp_stall/rsp_data carry the clock count of the divide and a
// zero divisor flag. A request is taken on an edge with valid high and
// stall low; one response comes back for each request, in order.
// Each taken request is registered in every stage before it shows on
// rsp_valid. Throughput: one request per cycle while nothing is stalled.
// The path is an entry stage (absolute values, overflow check, starting
// count) and five stages of three restoring divide steps each, 15 steps
// in all. Each stage holds one request and moves on whenever the next one
// is empty or moving, so bubbles close up behind a stalled response and
// requests are still taken until all six stages are full.
// Reset clears all valid bits; no request is in flight afterwards.
module div_instruction_cycle_count_core import dicc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    logic  valid_s [NumStepStages+1];
    logic  ready_s [NumStepStages+1];
    work_t data_s  [NumStepStages+1];
    logic  ready_front;
    work_t last;

    dicc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_ready (ready_front),
        .up_data  (req_data),
        .dn_valid (valid_s[0]),
        .dn_ready (ready_s[0]),
        .dn_data  (data_s[0])
    );

    for (genvar i = 0; i < NumStepStages; i++)
    begin : g_step
        dicc_step_stage u_step
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_s[i]),
            .up_ready (ready_s[i]),
            .up_data  (data_s[i]),
            .dn_valid (valid_s[i+1]),
            .dn_ready (ready_s[i+1]),
            .dn_data  (data_s[i+1])
        );
    end

    assign ready_s[NumStepStages] = !rsp_stall;
    assign req_stall              = !ready_front;

    assign last                  = data_s[NumStepStages];
    assign rsp_valid             = valid_s[NumStepStages];
    assign rsp_data.cycle_count  = {last.cnt, 1'b0};
    assign rsp_data.zero_divisor = last.zero;

`ifndef SYNTHESIS
    a_zero_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.zero_divisor |-> rsp_data.cycle_count == 8'd0)
        else $error("zero divisor with non-zero count");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.zero_divisor |-> rsp_data.cycle_count >= 8'd10)
        else $error("count too small for a real divide");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.cycle_count <= 8'd156)
        else $error("count above maximum");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for div_instruction_cycle_count_core: divide requests in,
// clock counts out, each compared with a count worked out here when the request is taken.
// Depends on dicc_pkg (request and response types) and the core itself.
module tb_top;
    import dicc_pkg::*;

    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_SIGNED   = 1'b1;

    // Half counts; the figure on the port is twice these.
    localparam int unsigned U_OVF_HALF  = 5;
    localparam int unsigned U_BASE_HALF = 38;
    localparam int unsigned S_OVF_HALF  = 8;
    localparam int unsigned S_ADJ_HALF  = 6;
    localparam int unsigned S_BODY_HALF = 55;
    localparam int          N_STEPS     = 15;

    localparam int NUM_RANDOM     = 750;
    localparam int HOLDOFF_START  = 300;
    localparam int HOLDOFF_CYCLES = 60;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    req_t instr_q[$];
    rsp_t count_q[$];

    int unsigned req_taken = 0;
    int unsigned rsp_seen = 0;
    int unsigned n_errors = 0;
    int unsigned n_zero = 0;
    int unsigned n_ovf = 0;
    int unsigned n_full = 0;
    int unsigned cycle_no = 0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned stall_clk = 0;
    int unsigned stall_run = 0;
    int unsigned holdoff_left = 0;
    bit stall_on = 1'b0;
    bit holdoff_done = 1'b0;
    bit saw_full = 1'b0;
    bit draining = 1'b0;
    rsp_t want;

    div_instruction_cycle_count_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Clock count of one divide instruction.
    function automatic rsp_t div_cycles(req_t r);
        rsp_t res;
        logic [31:0] w;
        logic [31:0] hd;
        logic [31:0] adv;
        logic [31:0] quo;
        logic [15:0] ads;
        logic carry;
        int unsigned half;
        res = '0;
        if (r.divisor == 16'd0)
        begin
            res.zero_divisor = 1'b1;
            return res;
        end
        if (r.req_type == MODE_UNSIGNED)
        begin
            if (r.dividend[31:16] >= r.divisor)
                half = U_OVF_HALF;
            else
            begin
                half = U_BASE_HALF;
                w = r.dividend;
                hd = {r.divisor, 16'h0000};
                for (int k = 0; k < N_STEPS; k++)
                begin
                    carry = w[31];
                    w = w << 1;
                    if (carry)
                        w = w - hd;
                    else
                    begin
                        half += 2;
                        if (w >= hd)
                        begin
                            w = w - hd;
                            half -= 1;
                        end
                    end
                end
            end
        end
        else
        begin
            adv = r.dividend[31] ? (32'd0 - r.dividend) : r.dividend;
            ads = r.divisor[15] ? (16'd0 - r.divisor) : r.divisor;
            half = r.dividend[31] ? S_ADJ_HALF + 1 : S_ADJ_HALF;
            if (adv[31:16] >= ads)
                half += 2;
            else
            begin
                quo = adv / {16'h0000, ads};
                half += S_BODY_HALF;
                if (!r.divisor[15])
                    half = r.dividend[31] ? half + 1 : half - 1;
                for (int k = 1; k <= N_STEPS; k++)
                    if (!quo[k])
                        half += 1;
            end
        end
        res.cycle_count = 8'(half * 2);
        return res;
    endfunction

    task automatic queue_div(input logic mode, input logic [31:0] dvd, input logic [15:0] dvs);
        req_t r;
        r.req_type = mode;
        r.dividend = dvd;
        r.divisor  = dvs;
        instr_q.push_back(r);
    endtask

    // Mostly divides that miss overflow, so the step chain does real work;
    // the rest are zero divisors and raw noise.
    function automatic req_t random_div();
        req_t r;
        int unsigned pick;
        logic [31:0] raw;
        logic [31:0] num;
        logic [15:0] mag;
        logic [15:0] hi;
        pick = $urandom_range(0, 99);
        raw = $urandom;
        r.req_type = raw[0];
        r.dividend = $urandom;
        raw = $urandom;
        r.divisor = raw[15:0];
        if (pick < 5)
            r.divisor = 16'd0;
        else if (pick >= 25)
        begin
            raw = $urandom_range(1, 16'hFFFF) >> $urandom_range(0, 15);
            mag = (raw[15:0] == 16'd0) ? 16'd1 : raw[15:0];
            if (r.req_type == MODE_SIGNED && mag > 16'h8000)
                mag = mag >> 1;
            raw = $urandom_range(0, mag - 1);
            hi = raw[15:0];
            raw = $urandom;
            num = {hi, raw[15:0]};
            if (r.req_type == MODE_UNSIGNED)
            begin
                r.divisor  = mag;
                r.dividend = num;
            end
            else
            begin
                r.dividend = raw[16] ? (32'd0 - num) : num;
                r.divisor  = (mag == 16'h8000 || raw[17]) ? (16'd0 - mag) : mag;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned exp_v,
                                   input int unsigned got_v);
        $display("mismatch at response %0d: %s expected %0d got %0d",
                 rsp_seen, what, exp_v, got_v);
        n_errors++;
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
        end
        else
        begin
            if (req_valid && req_stall)
                saw_full = 1'b1;
            if (req_valid && !req_stall)
            begin
                count_q.push_back(div_cycles(req_data));
                req_taken++;
            end
            if (!(req_valid && req_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (instr_q.size() > 0)
                begin
                    req_valid <= 1'b1;
                    req_data  <= instr_q.pop_front();
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response stall: alternating runs, plus one long hold-off to fill the pipe.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            stall_clk++;
            if (draining)
                rsp_stall <= 1'b0;
            else if (holdoff_left > 0)
            begin
                holdoff_left--;
                rsp_stall <= 1'b1;
            end
            else if (!holdoff_done && stall_clk >= HOLDOFF_START)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES - 1;
                rsp_stall <= 1'b1;
            end
            else
            begin
                if (stall_run > 0)
                    stall_run--;
                else
                begin
                    stall_on = !stall_on;
                    if (stall_on)
                        stall_run = $urandom_range(0, 4);
                    else if ($urandom_range(0, 3) == 0)
                        stall_run = $urandom_range(20, 60);
                    else
                        stall_run = $urandom_range(0, 6);
                end
                rsp_stall <= stall_on;
            end
        end
    end

    // Response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_seen++;
            if (count_q.size() == 0)
                report_mismatch("unrequested response, cycle_count", 0,
                                32'(rsp_data.cycle_count));
            else
            begin
                want = count_q.pop_front();
                if (rsp_data.cycle_count !== want.cycle_count)
                    report_mismatch("cycle_count", 32'(want.cycle_count),
                                    32'(rsp_data.cycle_count));
                if (rsp_data.zero_divisor !== want.zero_divisor)
                    report_mismatch("zero_divisor", 32'(want.zero_divisor),
                                    32'(rsp_data.zero_divisor));
                if (want.zero_divisor)
                    n_zero++;
                else if (want.cycle_count == 8'(2 * U_OVF_HALF) || want.cycle_count
                         == 8'(2 * S_OVF_HALF) || want.cycle_count == 8'(2 * S_OVF_HALF + 2))
                    n_ovf++;
                else
                    n_full++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_no++;
        if (cycle_no >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d requests, %0d responses",
                     cycle_no, req_taken, rsp_seen);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        // zero divisor in both modes
        queue_div(MODE_UNSIGNED, 32'h1234_5678, 16'h0000);
        queue_div(MODE_SIGNED,   32'h8000_0000, 16'h0000);
        // unsigned overflow and the extremes of the step chain
        queue_div(MODE_UNSIGNED, 32'hFFFF_FFFF, 16'hFFFF);
        queue_div(MODE_UNSIGNED, 32'h0001_0000, 16'h0001);
        queue_div(MODE_UNSIGNED, 32'h0000_0000, 16'h0001);
        queue_div(MODE_UNSIGNED, 32'h0000_FFFF, 16'h0001);
        queue_div(MODE_UNSIGNED, 32'hFFFE_FFFF, 16'hFFFF);
        queue_div(MODE_UNSIGNED, 32'h7FFF_FFFF, 16'h8000);
        queue_div(MODE_UNSIGNED, 32'hFFFE_0000, 16'hFFFF);
        queue_div(MODE_UNSIGNED, 32'h0000_AAAA, 16'h0003);
        // signed overflow: the most negative dividend always overflows
        queue_div(MODE_SIGNED,   32'h8000_0000, 16'h8000);
        queue_div(MODE_SIGNED,   32'h8000_0000, 16'h0001);
        queue_div(MODE_SIGNED,   32'h7FFF_FFFF, 16'h7FFF);
        // the four sign combinations without overflow
        queue_div(MODE_SIGNED,   32'h7FFE_FFFF, 16'h7FFF);
        queue_div(MODE_SIGNED,   32'h8001_0001, 16'h7FFF);
        queue_div(MODE_SIGNED,   32'h7FFE_FFFF, 16'h8001);
        queue_div(MODE_SIGNED,   32'h8001_0001, 16'h8001);
        queue_div(MODE_SIGNED,   32'h0000_0000, 16'hFFFF);
        queue_div(MODE_SIGNED,   32'h7FFF_FFFF, 16'h8000);
        queue_div(MODE_SIGNED,   32'hFFFF_FFFF, 16'h0001);
        queue_div(MODE_SIGNED,   32'h0000_FFFF, 16'h0001);
        queue_div(MODE_SIGNED,   32'hFFFF_0000, 16'h0002);
        for (int i = 0; i < NUM_RANDOM; i++)
            instr_q.push_back(random_div());

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (instr_q.size() > 0 || req_valid || count_q.size() > 0);
        draining <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d divide requests checked: %0d zero divisor, %0d overflow, %0d full step",
                 rsp_seen, n_zero, n_ovf, n_full);
        $display("response hold-off of %0d cycles, input back-pressure seen: %0d",
                 HOLDOFF_CYCLES, saw_full);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
